@@ rtl/ksmq_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the keyed sequenced message queue
// no dependencies; imported by the interfaces and the top level

package ksmq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int STAMP_W  = 64;
  localparam int HANDLE_W = 32;
  localparam int SEQ_W    = 32;

  // operation codes
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;

  // one stored queue entry
  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
    logic [SEQ_W-1:0]    seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/ksmq_if.sv @@
`timescale 1ns / 1ps
// request and result channel interfaces (valid/ready) of the message queue
// depends on ksmq_pkg for field widths

interface ksmq_req_if;
  import ksmq_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [STAMP_W-1:0]  stamp;
  logic [HANDLE_W-1:0] message_handle;
  logic                keep_message;

  modport source (output valid, operation, stamp, message_handle, keep_message,
                  input ready);
  modport sink (input valid, operation, stamp, message_handle, keep_message,
                output ready);
endinterface

interface ksmq_rsp_if;
  import ksmq_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [SEQ_W-1:0]    assigned_seq;
  logic                found;
  logic [HANDLE_W-1:0] returned_handle;
  logic [SEQ_W-1:0]    current_seq;
  logic [SEQ_W-1:0]    next_seq;
  logic [CNT_W-1:0]    fill_level;

  modport source (output valid, status, assigned_seq, found, returned_handle,
                  current_seq, next_seq, fill_level, input ready);
  modport sink (input valid, status, assigned_seq, found, returned_handle,
                current_seq, next_seq, fill_level, output ready);
endinterface

@@ rtl/ksmq_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module ksmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/keyed_sequenced_message_queue_unit.sv @@
`timescale 1ns / 1ps
// top level of the keyed sequenced message queue
// depends on ksmq_pkg, ksmq_if (request/result interfaces) and ksmq_ram

// The queue keeps up to QUEUE_DEPTH entries (stamp, handle, sequence) in one
// synchronous ram, oldest at address 0. Every request beat yields exactly one
// result beat. Add and advance are accepted, then loaded into the output
// register once it is free. A remove walks the ram one entry at a time (read,
// then compare), and after a hit moves every younger entry down one slot (read,
// then write); both walks use the single ram read port. The next request is
// taken as soon as the unit is back in idle, even while the previous result
// still waits in the output register. The user must write inactive through
// cfg_we/cfg_data only while the unit is idle; the block does not enforce it.

module keyed_sequenced_message_queue_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_data,
  ksmq_req_if.sink       req,
  ksmq_rsp_if.source     rsp
);
  import ksmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  state_t state;

  // architectural state
  logic                inactive;
  logic [SEQ_W-1:0]    seq_cnt;
  logic [CNT_W-1:0]    count;

  // working registers of a remove
  logic [CNT_W-1:0]    idx;
  logic [STAMP_W-1:0]  key;
  logic                keep;

  // result held until the output register is free
  logic [1:0]          res_status;
  logic [SEQ_W-1:0]    res_assigned;
  logic                res_found;
  logic [HANDLE_W-1:0] res_handle;

  // output register
  logic                out_valid;
  logic [1:0]          out_status;
  logic [SEQ_W-1:0]    out_assigned;
  logic                out_found;
  logic [HANDLE_W-1:0] out_handle;
  logic [SEQ_W-1:0]    out_cur;
  logic [SEQ_W-1:0]    out_nxt;
  logic [CNT_W-1:0]    out_fill;

  // ram ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  entry_t              ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  entry_t              ram_rdata;

  logic                req_fire;
  logic                add_ok;
  logic                queue_full;
  logic [SEQ_W-1:0]    seq_inc;
  logic [CNT_W-1:0]    idx_dec;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign queue_full = (count == CNT_W'(QUEUE_DEPTH));
  assign add_ok     = (req.operation == OP_ADD) && !queue_full && !inactive;
  assign seq_inc    = seq_cnt + SEQ_W'(1);
  assign idx_dec    = idx - CNT_W'(1);

  // ram access: append on add, move down one slot while compacting
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[ADDR_W-1:0];
    if (state == S_IDLE && req_fire && add_ok) begin
      ram_we           = 1'b1;
      ram_wdata.stamp  = req.stamp;
      ram_wdata.handle = req.message_handle;
      ram_wdata.seq    = seq_inc;
    end else if (state == S_SHIFT_WR) begin
      ram_we    = 1'b1;
      ram_waddr = idx_dec[ADDR_W-1:0];
    end
  end

  ksmq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inactive  <= 1'b0;
      seq_cnt   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        inactive <= cfg_data;
      end

      // result beat taken downstream; a waiting result reloads the register instead
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            res_found  <= 1'b0;
            res_handle <= '0;
            key        <= req.stamp;
            keep       <= req.keep_message;
            idx        <= '0;
            case (req.operation)
              OP_ADD: begin
                state <= S_DONE;
                if (queue_full) begin
                  res_status   <= ST_FULL;
                  res_assigned <= '0;
                end else if (inactive) begin
                  res_status   <= ST_INACTIVE;
                  res_assigned <= '0;
                end else begin
                  res_status   <= ST_DONE;
                  res_assigned <= seq_inc;
                  seq_cnt      <= seq_inc;
                  count        <= count + CNT_W'(1);
                end
              end
              OP_REMOVE: begin
                res_status   <= ST_DONE;
                res_assigned <= '0;
                state        <= S_SCAN_RD;
              end
              OP_ADVANCE: begin
                res_status   <= ST_DONE;
                res_assigned <= '0;
                seq_cnt      <= seq_inc;
                state        <= S_DONE;
              end
              default: begin
                // unused code: report state unchanged
                res_status   <= ST_DONE;
                res_assigned <= '0;
                state        <= S_DONE;
              end
            endcase
          end
        end

        // walk from the oldest entry looking for the key
        S_SCAN_RD: begin
          if (idx == count) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end

        S_SCAN_CHK: begin
          idx <= idx + CNT_W'(1);
          if (ram_rdata.stamp == key) begin
            res_found  <= 1'b1;
            res_handle <= keep ? ram_rdata.handle : '0;
            state      <= S_SHIFT_RD;
          end else begin
            state <= S_SCAN_RD;
          end
        end

        // close the gap: entry idx moves to idx - 1
        S_SHIFT_RD: begin
          if (idx == count) begin
            count <= count - CNT_W'(1);
            state <= S_DONE;
          end else begin
            state <= S_SHIFT_WR;
          end
        end

        S_SHIFT_WR: begin
          idx   <= idx + CNT_W'(1);
          state <= S_SHIFT_RD;
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_status   <= res_status;
            out_assigned <= res_assigned;
            out_found    <= res_found;
            out_handle   <= res_handle;
            out_cur      <= seq_cnt;
            out_nxt      <= seq_inc;
            out_fill     <= count;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.assigned_seq    = out_assigned;
  assign rsp.found           = out_found;
  assign rsp.returned_handle = out_handle;
  assign rsp.current_seq     = out_cur;
  assign rsp.next_seq        = out_nxt;
  assign rsp.fill_level      = out_fill;

endmodule
